>>> rtl/core/lrc_pkg.sv
// Shared types and constants for the LED ring chase controller.
// No dependencies; imported by the controller, the datapath and the top level.
package lrc_pkg;

  localparam int IN_W       = 96;
  localparam int OUT_W      = 32;
  localparam int POS_W      = 8;
  localparam int COLOR_W    = 24;
  localparam int LED_CNT_W  = 5;
  localparam int THR_W      = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PIX_IDX_W  = 4;

  typedef enum logic [3:0] {
    OP_RESTART    = 4'd0,
    OP_POWER      = 4'd1,
    OP_RELAY      = 4'd2,
    OP_CONFIGURE  = 4'd3,
    OP_PRESENCE   = 4'd4,
    OP_SELECT     = 4'd5,
    OP_DESELECT   = 4'd6,
    OP_DISCONNECT = 4'd7,
    OP_TICK       = 4'd8
  } op_t;

  localparam logic [CFG_ADDR_W-1:0] REG_LED_COUNT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_THR  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_YELLOW_THR = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_THR    = 2'd3;

  localparam logic signed [THR_W-1:0] GREEN_THR_RST  = 32'sd100;
  localparam logic signed [THR_W-1:0] YELLOW_THR_RST = 32'sd500;
  localparam logic signed [THR_W-1:0] RED_THR_RST    = 32'sd1000;

  // colors packed {red, green, blue}
  localparam logic [COLOR_W-1:0] COLOR_BLACK  = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_PURPLE = 24'h660066;
  localparam logic [COLOR_W-1:0] COLOR_BLUE   = 24'h0000FF;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 24'h00FF00;

  localparam logic [POS_W-1:0] DIR_FWD  = 8'd1;
  localparam logic [POS_W-1:0] DIR_BACK = 8'd2;

  // input word, first field in the highest bits
  typedef struct packed {
    logic [7:0]              blue;
    logic [7:0]              green;
    logic [7:0]              red;
    logic [7:0]              direction;
    logic [7:0]              start_position;
    logic [3:0]              led_index;
    logic [7:0]              near_byte;
    logic [7:0]              relay_byte;
    logic signed [THR_W-1:0] power;
    op_t                     op;
  } item_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic skip;
    logic emit_behind;
    logic emit_ahead;
    logic emit_blank;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic scan_end;
    logic any_mover;
    logic cur_moves;
    logic is_last_mover;
    logic pix_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/lrc_ctrl.sv
// Sequencer for the LED ring chase controller: accepts words, walks the
// scan, chase and blanking passes. Depends on lrc_pkg; drives lrc_datapath.
module lrc_ctrl
  import lrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  op_t        op,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_BEHIND = 5'b00100,
    ST_AHEAD  = 5'b01000,
    ST_BLANK  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (op == OP_DISCONNECT) begin
            state_next = ST_BLANK;
          end else if (op == OP_TICK && st.tick_go) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_end) begin
          state_next = st.any_mover ? ST_BEHIND : ST_IDLE;
        end
      end
      ST_BEHIND: begin
        // pass over still entries, wait for room before the black word
        if (!st.cur_moves) begin
          cmd.skip = 1'b1;
        end else if (st.out_free) begin
          cmd.emit_behind = 1'b1;
          state_next      = ST_AHEAD;
        end
      end
      ST_AHEAD: begin
        if (st.out_free) begin
          cmd.emit_ahead = 1'b1;
          state_next     = st.is_last_mover ? ST_IDLE : ST_BEHIND;
        end
      end
      ST_BLANK: begin
        if (st.out_free) begin
          cmd.emit_blank = 1'b1;
          if (st.pix_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.scan_step, cmd.skip,
              cmd.emit_behind, cmd.emit_ahead, cmd.emit_blank}))
    else $error("more than one datapath command in a cycle");

  a_last_mover_moves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BEHIND && st.is_last_mover) |-> st.cur_moves)
    else $error("chase pass reached the last mover on a still entry");

  a_tick_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_AHEAD && state == ST_IDLE) |->
      $past(cmd.emit_ahead && st.is_last_mover))
    else $error("tick ended before the last mover was written");

  a_blank_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_BLANK && state == ST_IDLE) |->
      $past(cmd.emit_blank && st.pix_last))
    else $error("blanking ended before the last pixel");

endmodule

>>> rtl/core/lrc_datapath.sv
// Datapath for the LED ring chase controller: LED tables, command state,
// ring wrap arithmetic and the output word register. Depends on lrc_pkg.
module lrc_datapath
  import lrc_pkg::*;
#(
  parameter int RING_SIZE = 12,
  parameter int MAX_LEDS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  item_t                 item,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            st,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W = $clog2(MAX_LEDS + 1);
  localparam int NW    = LED_CNT_W + 1;
  localparam logic [NW-1:0]    MAX_N     = NW'(MAX_LEDS);
  localparam logic [POS_W-1:0] RING_TOP  = POS_W'(RING_SIZE);
  localparam logic [POS_W-1:0] RING_LAST = POS_W'(RING_SIZE - 1);

  // position modulo ring size for every 8-bit position, built by counting
  function automatic logic [256*POS_W-1:0] build_mod_tab();
    logic [256*POS_W-1:0] tab;
    logic [POS_W-1:0]     m;
    tab = '0;
    m   = '0;
    for (int i = 0; i < 256; i++) begin
      tab[i*POS_W +: POS_W] = m;
      m = (m == RING_LAST) ? '0 : m + 1'b1;
    end
    return tab;
  endfunction

  localparam logic [256*POS_W-1:0] MOD_TAB = build_mod_tab();

  // configuration
  logic [LED_CNT_W-1:0]    led_count;
  logic signed [THR_W-1:0] green_thr, yellow_thr, red_thr;

  // LED tables, no reset
  logic [POS_W-1:0]   pos_tab [MAX_LEDS];
  logic [POS_W-1:0]   dir_tab [MAX_LEDS];
  logic [COLOR_W-1:0] col_tab [MAX_LEDS];
  logic               sel_tab [MAX_LEDS];

  // command state
  logic [COLOR_W-1:0] gen_color;
  logic [7:0]         relay_state, presence_state;
  logic [CNT_W-1:0]   cc;
  logic               motion_en;

  // pass state
  logic [IDX_W-1:0]   ent, last_mover;
  logic [POS_W-1:0]   pix;
  logic               hb, has_mover;

  // output word
  logic                 o_valid;
  logic [PIX_IDX_W-1:0] o_index;
  logic [COLOR_W-1:0]   o_rgb;
  logic                 o_hb, o_last;

  logic [NW-1:0]      lc_ext, n_full;
  logic [CNT_W-1:0]   n;
  logic               in_acc, cfg_room, idx_ok, motion_set;
  logic [IDX_W-1:0]   cc_idx, sel_idx;
  logic [COLOR_W-1:0] gen_new;
  logic               is_near;

  logic [POS_W-1:0]   cur_pos, cur_dir, w, wm, behind, new_pos;
  logic [COLOR_W-1:0] cur_col;
  logic               fwd, back;
  logic               d0_moves, first_zero, later_zero, scan_hit;
  logic               emit_any, out_free;

  assign lc_ext  = {1'b0, led_count};
  assign n_full  = (lc_ext < MAX_N) ? lc_ext : MAX_N;
  assign n       = CNT_W'(n_full);
  assign in_acc  = cmd.accept;

  assign cfg_room   = cc < n;
  assign cc_idx     = cc[IDX_W-1:0];
  assign motion_set = (NW'(cc) + 1'b1) >= lc_ext;
  assign idx_ok     = NW'(item.led_index) < n_full;
  assign sel_idx    = IDX_W'(item.led_index);

  // general color from a power sample
  assign is_near = presence_state == 8'd1;
  always_comb begin
    if (is_near && relay_state == 8'd0) begin
      gen_new = COLOR_PURPLE;
    end else if (is_near && item.power < green_thr) begin
      gen_new = COLOR_GREEN;
    end else if (is_near && item.power < yellow_thr) begin
      gen_new = COLOR_YELLOW;
    end else if (is_near && item.power > red_thr) begin
      gen_new = COLOR_RED;
    end else begin
      gen_new = COLOR_BLACK;
    end
  end

  // current entry and its wrap
  assign cur_pos = pos_tab[ent];
  assign cur_dir = dir_tab[ent];
  assign cur_col = col_tab[ent];
  assign fwd     = cur_dir == DIR_FWD;
  assign back    = cur_dir == DIR_BACK;

  always_comb begin
    if (fwd) begin
      w = (cur_pos >= RING_TOP) ? '0 : cur_pos;
    end else begin
      w = (cur_pos == '0) ? RING_TOP : cur_pos;
    end
    wm = MOD_TAB[{w, 3'b000} +: POS_W];
    if (fwd) begin
      behind  = (w == '0) ? RING_LAST : w - 1'b1;
      new_pos = w + 1'b1;
    end else begin
      behind  = (wm == RING_LAST) ? '0 : wm + 1'b1;
      new_pos = w - 1'b1;
    end
  end

  // heartbeat: entry zero's position as seen when each mover is stepped
  assign d0_moves   = dir_tab[0] == DIR_FWD || dir_tab[0] == DIR_BACK;
  assign first_zero = dir_tab[0] == DIR_FWD &&
                      (pos_tab[0] == '0 || pos_tab[0] >= RING_TOP);
  assign later_zero = d0_moves ? (dir_tab[0] == DIR_BACK && pos_tab[0] == 8'd1)
                               : (pos_tab[0] == '0);
  assign scan_hit   = (fwd || back) && ((ent == '0) ? first_zero : later_zero);

  assign emit_any = cmd.emit_behind || cmd.emit_ahead || cmd.emit_blank;
  assign out_free = !o_valid || m_tready;

  assign st.tick_go       = motion_en && n != '0;
  assign st.scan_end      = CNT_W'(ent) == n - 1'b1;
  assign st.any_mover     = has_mover || fwd || back;
  assign st.cur_moves     = fwd || back;
  assign st.is_last_mover = ent == last_mover;
  assign st.pix_last      = pix == RING_LAST;
  assign st.out_free      = out_free;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count      <= '0;
      green_thr      <= GREEN_THR_RST;
      yellow_thr     <= YELLOW_THR_RST;
      red_thr        <= RED_THR_RST;
      gen_color      <= COLOR_BLACK;
      relay_state    <= '0;
      presence_state <= '0;
      cc             <= '0;
      motion_en      <= 1'b0;
      o_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_LED_COUNT:  led_count  <= cfg_data[LED_CNT_W-1:0];
          REG_GREEN_THR:  green_thr  <= cfg_data;
          REG_YELLOW_THR: yellow_thr <= cfg_data;
          REG_RED_THR:    red_thr    <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (item.op)
          OP_RESTART: begin
            cc             <= '0;
            motion_en      <= 1'b0;
            relay_state    <= item.relay_byte;
            presence_state <= item.near_byte;
          end
          OP_POWER:    gen_color      <= gen_new;
          OP_RELAY:    relay_state    <= item.relay_byte;
          OP_PRESENCE: presence_state <= item.near_byte;
          OP_CONFIGURE: begin
            if (cfg_room) begin
              cc <= cc + 1'b1;
              if (motion_set) begin
                motion_en <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (emit_any) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // tables and pass registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (item.op)
        OP_POWER: begin
          for (int i = 0; i < MAX_LEDS; i++) begin
            if (NW'(i) < n_full && !sel_tab[i]) begin
              col_tab[i] <= gen_new;
            end
          end
        end
        OP_CONFIGURE: begin
          if (cfg_room) begin
            pos_tab[cc_idx] <= item.start_position;
            dir_tab[cc_idx] <= item.direction;
            col_tab[cc_idx] <= {item.red, item.green, item.blue};
            sel_tab[cc_idx] <= 1'b0;
          end
        end
        OP_SELECT: begin
          if (idx_ok) begin
            col_tab[sel_idx] <= COLOR_BLUE;
            sel_tab[sel_idx] <= 1'b1;
          end
        end
        OP_DESELECT: begin
          if (idx_ok) begin
            col_tab[sel_idx] <= gen_color;
            sel_tab[sel_idx] <= 1'b0;
          end
        end
        OP_DISCONNECT: begin
          for (int i = 0; i < MAX_LEDS; i++) begin
            if (NW'(i) < n_full) begin
              col_tab[i] <= COLOR_BLACK;
            end
          end
        end
        default: ;
      endcase
      ent       <= '0;
      pix       <= '0;
      hb        <= 1'b0;
      has_mover <= 1'b0;
    end
    if (cmd.scan_step) begin
      hb <= hb | scan_hit;
      if (fwd || back) begin
        has_mover  <= 1'b1;
        last_mover <= ent;
      end
      ent <= st.scan_end ? '0 : ent + 1'b1;
    end
    if (cmd.skip) begin
      ent <= ent + 1'b1;
    end
    if (cmd.emit_ahead) begin
      pos_tab[ent] <= new_pos;
      ent          <= ent + 1'b1;
    end
    if (cmd.emit_blank) begin
      pix <= pix + 1'b1;
    end
    if (cmd.emit_behind) begin
      o_index <= behind[PIX_IDX_W-1:0];
      o_rgb   <= COLOR_BLACK;
      o_hb    <= hb;
      o_last  <= 1'b0;
    end else if (cmd.emit_ahead) begin
      o_index <= wm[PIX_IDX_W-1:0];
      o_rgb   <= cur_col;
      o_hb    <= hb;
      o_last  <= st.is_last_mover;
    end else if (cmd.emit_blank) begin
      o_index <= pix[PIX_IDX_W-1:0];
      o_rgb   <= COLOR_BLACK;
      o_hb    <= 1'b0;
      o_last  <= st.pix_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {4'b0000, o_rgb[7:0], o_rgb[15:8], o_rgb[23:16], o_index};
  assign m_tuser  = o_hb;
  assign m_tlast  = o_last;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(emit_any && o_valid && !m_tready))
    else $error("output word overwritten while stalled");

  a_motion_needs_entries: assert property (@(posedge clk) disable iff (rst)
    motion_en |-> cc != '0)
    else $error("motion enabled with no configured entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cc <= CNT_W'(MAX_LEDS))
    else $error("configured count beyond table depth");

endmodule

>>> rtl/core/led_ring_chase_controller.sv
// Top level of the LED ring chase controller: command stream in, pixel write stream out.
// A pixel word is registered and shows on m_tvalid in the cycle after it is built.
// Most commands finish in the accept cycle; disconnect writes RING_SIZE blank words; tick
// scans the N active LEDs, then writes two words per moving LED and skips still LEDs up to
// the last mover, one entry at a time and one output word per cycle unless the output stalls.
// Reset (rst, synchronous, active high) clears control state, reloads default thresholds.
module led_ring_chase_controller
  import lrc_pkg::*;
#(
  parameter int RING_SIZE = 12,
  parameter int MAX_LEDS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port: index 0 led_count, 1 green, 2 yellow, 3 red threshold
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // command stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, low to high: op[3:0], power[35:4], relay_byte[43:36],
  // near_byte[51:44], led_index[55:52], start_position[63:56],
  // direction[71:64], red[79:72], green[87:80], blue[95:88]
  input  logic [IN_W-1:0]       s_tdata,
  // pixel stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, low to high: pixel_index[3:0], pixel_red[11:4],
  // pixel_green[19:12], pixel_blue[27:20], zero fill [31:28]
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tuser,   // heartbeat
  output logic                  m_tlast    // last pixel word of the command
);

  item_t      item;
  ctrl_cmd_t  cmd;
  dp_status_t st;

  // unpack the command word; fields are used only in the accept cycle
  assign item = item_t'(s_tdata);

  // sequencer: accept, then scan / chase / blank passes
  lrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (item.op),
    .st       (st),
    .cmd      (cmd)
  );

  // tables, wrap arithmetic and the output word register
  lrc_datapath #(
    .RING_SIZE (RING_SIZE),
    .MAX_LEDS  (MAX_LEDS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
